// ===== rtl/core/ble_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ble_pkg;

  // operation selectors
  localparam logic [2:0] FUNC_INS_FRONT = 3'd0;
  localparam logic [2:0] FUNC_INS_BACK  = 3'd1;
  localparam logic [2:0] FUNC_DEL_FRONT = 3'd2;
  localparam logic [2:0] FUNC_DEL_BACK  = 3'd3;
  localparam logic [2:0] FUNC_DEL_VALUE = 3'd4;
  localparam logic [2:0] FUNC_REVERSE   = 3'd5;
  localparam logic [2:0] FUNC_READ      = 3'd6;

  // result status codes
  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_FULL      = 3'd1;
  localparam logic [2:0] STATUS_EMPTY     = 3'd2;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd3;
  localparam logic [2:0] STATUS_RANGE     = 3'd4;

  // command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_SHIFT_UP,
    CMD_SHIFT_DOWN,
    CMD_LOAD
  } ble_cmd_e;

endpackage

`default_nettype wire

// ===== rtl/core/ble_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ble_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned IDX        = 0
) (
  input  wire                   clk_i,
  input  ble_pkg::ble_cmd_e     cmd_i,
  input  wire [IDX_W-1:0]       idx_i,
  input  wire [DATA_WIDTH-1:0]  value_i,
  input  wire [DATA_WIDTH-1:0]  left_i,
  input  wire [DATA_WIDTH-1:0]  right_i,
  output logic [DATA_WIDTH-1:0] data_o
);
  import ble_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (cmd_i)
      CMD_HOLD:       data_d = data_q;
      // the first cell takes the new word, the rest take their lower neighbour
      CMD_SHIFT_UP:   data_d = (IDX == 0) ? value_i : left_i;
      // cells from the given index upward take their upper neighbour
      CMD_SHIFT_DOWN: data_d = (MyIdx >= idx_i) ? right_i : data_q;
      CMD_LOAD:       data_d = (MyIdx == idx_i) ? value_i : data_q;
      default:        data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== rtl/core/bounded_list_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bounded ordered list of up to DEPTH signed words, held in a ring of DEPTH
// cells where cell 0 is the low end. One request gives one result. Inserts,
// deletes at the low end, reverse, unused selectors and the full, empty and
// out of range cases need no rotation: the result register is loaded at
// the accepting edge. A read, a delete at the high end and a delete by value
// (found or not) rotate the whole ring once past cell 0 in S_SCAN, then
// close in S_FINISH, which loads the result register; the next request is
// taken once back in S_IDLE. Reverse only flips the walking direction; no
// data moves. A new request is taken while the previous result is being
// handed over; a result left waiting holds off the next request.
module bounded_list_engine #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire [2:0]         func_i,
  input  wire signed [31:0] value_i,
  input  wire [4:0]         position_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic signed [31:0] read_data_o,
  output logic [2:0]        status_o,
  output logic [4:0]        count_o
);
  import ble_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > 5) ? CW : 5;
  localparam logic [IW-1:0] LastIdx = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCount = CW'(DEPTH);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  function automatic logic [31:0] sext(input logic [DATA_WIDTH-1:0] d);
    logic [DATA_WIDTH+31:0] w;
    w = {{32{d[DATA_WIDTH-1]}}, d};
    return w[31:0];
  endfunction

  logic [1:0]            state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  rev_q, rev_d;
  logic [2:0]            func_q, func_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [IW-1:0]         tgt_q, tgt_d;
  logic [IW-1:0]         step_q, step_d;
  logic                  hit_q, hit_d;
  logic [IW-1:0]         hit_idx_q, hit_idx_d;
  logic [DATA_WIDTH-1:0] cap_q, cap_d;

  logic                  out_valid_q, out_valid_d;
  logic [31:0]           out_data_q, out_data_d;
  logic [2:0]            out_status_q, out_status_d;
  logic [4:0]            out_count_q;
  logic                  out_load;

  ble_cmd_e              cmd;
  logic [IW-1:0]         cmd_idx;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];

  logic                  accept;
  logic [DATA_WIDTH+31:0] val_wide;
  logic [DATA_WIDTH-1:0] value_w;
  logic [PW-1:0]         pos_w, cnt_w, log_idx, phys_idx, cnt_out;
  logic                  is_full, is_empty, pos_range;

  assign val_wide = {{DATA_WIDTH{1'b0}}, value_i};
  assign value_w  = val_wide[DATA_WIDTH-1:0];

  assign pos_w     = PW'(position_i);
  assign cnt_w     = PW'(count_q);
  assign log_idx   = (pos_w == '0) ? '0 : pos_w - PW'(1);
  // a reversed list is walked from the high end of the ring
  assign phys_idx  = rev_q ? (cnt_w - PW'(1) - log_idx) : log_idx;
  assign is_full   = (count_q == FullCount);
  assign is_empty  = (count_q == '0);
  assign pos_range = (pos_w > cnt_w);

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rev_d        = rev_q;
    func_d       = func_q;
    val_d        = val_q;
    tgt_d        = tgt_q;
    step_d       = step_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    cap_d        = cap_q;
    cmd          = CMD_HOLD;
    cmd_idx      = '0;
    out_load     = 1'b0;
    out_data_d   = '0;
    out_status_d = STATUS_OK;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          func_d = func_i;
          val_d  = value_w;
          step_d = '0;
          hit_d  = 1'b0;
          case (func_i)
            FUNC_INS_FRONT, FUNC_INS_BACK: begin
              out_load = 1'b1;
              if (is_full) begin
                out_status_d = STATUS_FULL;
              end else begin
                if ((func_i == FUNC_INS_FRONT) != rev_q) begin
                  cmd = CMD_SHIFT_UP;
                end else begin
                  cmd     = CMD_LOAD;
                  cmd_idx = count_q[IW-1:0];
                end
                count_d = count_q + CW'(1);
              end
            end
            FUNC_DEL_FRONT, FUNC_DEL_BACK: begin
              if (is_empty) begin
                out_load     = 1'b1;
                out_status_d = STATUS_EMPTY;
              end else if ((func_i == FUNC_DEL_FRONT) != rev_q) begin
                out_load   = 1'b1;
                out_data_d = sext(cell_data[0]);
                cmd        = CMD_SHIFT_DOWN;
                count_d    = count_q - CW'(1);
              end else begin
                tgt_d   = IW'(count_q - CW'(1));
                state_d = S_SCAN;
              end
            end
            FUNC_DEL_VALUE: begin
              if (is_empty) begin
                out_load     = 1'b1;
                out_status_d = STATUS_EMPTY;
              end else begin
                state_d = S_SCAN;
              end
            end
            FUNC_REVERSE: begin
              out_load = 1'b1;
              rev_d    = !rev_q;
            end
            FUNC_READ: begin
              if (is_empty) begin
                out_load     = 1'b1;
                out_status_d = STATUS_EMPTY;
              end else if (pos_range) begin
                out_load     = 1'b1;
                out_status_d = STATUS_RANGE;
              end else begin
                tgt_d   = phys_idx[IW-1:0];
                state_d = S_SCAN;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // rotate the ring: cell 0 holds the word at ring index step_q
        cmd = CMD_SHIFT_DOWN;
        if (func_q == FUNC_DEL_VALUE) begin
          // walking reversed, the last match in ring order comes first
          if ((CW'(step_q) < count_q) && (cell_data[0] == val_q) && (rev_q || !hit_q)) begin
            hit_d     = 1'b1;
            hit_idx_d = step_q;
            cap_d     = cell_data[0];
          end
        end else if (step_q == tgt_q) begin
          cap_d = cell_data[0];
        end
        if (step_q == LastIdx) begin
          step_d  = '0;
          state_d = S_FINISH;
        end else begin
          step_d = step_q + IW'(1);
        end
      end
      S_FINISH: begin
        out_load = 1'b1;
        state_d  = S_IDLE;
        case (func_q)
          FUNC_DEL_VALUE: begin
            if (hit_q) begin
              cmd        = CMD_SHIFT_DOWN;
              cmd_idx    = hit_idx_q;
              count_d    = count_q - CW'(1);
              out_data_d = sext(cap_q);
            end else begin
              out_status_d = STATUS_NOT_FOUND;
            end
          end
          FUNC_DEL_FRONT, FUNC_DEL_BACK: begin
            count_d    = count_q - CW'(1);
            out_data_d = sext(cap_q);
          end
          default: begin
            out_data_d = sext(cap_q);
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cnt_out = PW'(count_d);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    ble_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .IDX_W     (IW),
      .IDX       (g)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .idx_i  (cmd_idx),
      .value_i(value_w),
      .left_i (cell_data[(g + DEPTH - 1) % DEPTH]),
      .right_i(cell_data[(g + 1) % DEPTH]),
      .data_o (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rev_q       <= 1'b0;
      step_q      <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rev_q       <= rev_d;
      step_q      <= step_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    val_q     <= val_d;
    tgt_q     <= tgt_d;
    hit_idx_q <= hit_idx_d;
    cap_q     <= cap_d;
    if (out_load) begin
      out_data_q   <= out_data_d;
      out_status_q <= out_status_d;
      out_count_q  <= cnt_out[4:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign status_o    = out_status_q;
  assign count_o     = out_count_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("element count above depth");

  a_scan_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && step_q == LastIdx) |=> (state_q == S_FINISH))
    else $error("rotation did not close after a full turn");

  a_hit_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && hit_q) |-> (CW'(hit_idx_q) < count_q))
    else $error("match recorded outside the live elements");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_full && (func_i == FUNC_INS_FRONT || func_i == FUNC_INS_BACK))
    |=> (out_valid_o && status_o == STATUS_FULL))
    else $error("insert on a full list not flagged");

  a_empty_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STATUS_EMPTY) |-> (count_o == 5'd0))
    else $error("empty status with non-zero count");
`endif

endmodule

`default_nettype wire
